// ===== hw/rtl/dds_pkg.sv =====
package dds_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int PHASE_W     = 32;
    localparam int SAMPLE_W    = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_WAVEFORM        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_INCREMENT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_PHASE     = 2'd2;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } wave_t;

    localparam int                   AMP        = 32000;
    localparam logic [14:0]          AMP_U      = 15'd32000;
    localparam logic signed [15:0]   SAMPLE_POS = 16'sd32000;
    localparam logic signed [15:0]   SAMPLE_NEG = -16'sd32000;
    localparam logic signed [48:0]   AMP_SH30   = 49'sd34359738368000;
    localparam logic signed [48:0]   AMP_SH31   = 49'sd68719476736000;
    localparam logic signed [48:0]   AMP3_SH30  = 49'sd103079215104000;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

    // (2n)(2n+1) for the odd-power sine series
    localparam logic [63:0] TAYLOR_DIV [30] = '{
        64'd1,    64'd6,    64'd20,   64'd42,   64'd72,   64'd110,  64'd156,  64'd210,
        64'd272,  64'd342,  64'd420,  64'd506,  64'd600,  64'd702,  64'd812,  64'd930,
        64'd1056, 64'd1190, 64'd1332, 64'd1482, 64'd1640, 64'd1806, 64'd1980, 64'd2162,
        64'd2352, 64'd2550, 64'd2756, 64'd2970, 64'd3192, 64'd3422
    };

    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[63:0] >> s | (prod[127:64] << (64 - s));
    endfunction

    function automatic logic [31:0] quarter_sine(input int j, input int bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = mul_shift(PI_Q62, 64'(2 * j), bits);
        x2   = mul_shift(x, x, 62);
        term = x;
        sum  = x;
        for (int n = 1; n < 30 && term != 64'd0; n++)
        begin
            term = mul_shift(term, x2, 62) / TAYLOR_DIV[n];
            if ((n & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        r = mul_shift(sum, 64'(AMP), 62);
        if (r > 64'(AMP))
            r = 64'(AMP);
        return r[31:0];
    endfunction

    function automatic logic signed [15:0] sine_entry(input int k, input int bits);
        int          q;
        int          quad;
        int          j;
        int          m;
        logic [31:0] v;
        q    = 1 << (bits - 2);
        quad = k >> (bits - 2);
        j    = k & (q - 1);
        m    = ((quad & 1) != 0) ? q - j : j;
        if (m == 0)
            v = 32'd0;
        else if (m == q)
            v = 32'(AMP);
        else
            v = quarter_sine(m, bits);
        if ((quad & 2) != 0)
            v = -v;
        return v[15:0];
    endfunction

    // num / 2^30 or num / 2^31, truncated toward zero
    function automatic logic signed [16:0] div_trunc(input logic signed [48:0] num,
                                                     input logic sh31);
        logic        neg;
        logic [48:0] mag;
        logic [48:0] q;
        neg = num[48];
        mag = neg ? 49'(-num) : 49'(num);
        q   = sh31 ? (mag >> 31) : (mag >> 30);
        return neg ? 17'(-q) : 17'(q);
    endfunction

endpackage

// ===== hw/rtl/dds_waveform_generator.sv =====
// Pipeline: an accepted request passes the s1 registers and then the output register.
// Throughput: one request per cycle unless m_tready stalls the output; the phase add
// is combinational and the sine table read is registered in the first stage.
// Reset: rst_n clears the accumulator, the configuration registers and all valid flags;
// the sine table is constant and needs no clearing.
module dds_waveform_generator #(
    parameter int SINE_TABLE_DEPTH = dds_pkg::SINE_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dds_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [0] restart
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [47:0]                    m_tdata,  // [15:0] sample, [47:16] phase_after
    output logic                           m_tlast
);

    localparam int ROM_BITS  = $clog2(SINE_TABLE_DEPTH + 1) - 1;
    localparam int ROM_DEPTH = 1 << ROM_BITS;

    logic signed [dds_pkg::SAMPLE_W-1:0] sine_rom [ROM_DEPTH];

    for (genvar k = 0; k < ROM_DEPTH; k++)
    begin : g_rom
        assign sine_rom[k] = dds_pkg::sine_entry(k, ROM_BITS);
    end

    dds_pkg::wave_t                waveform_reg;
    logic [dds_pkg::PHASE_W-1:0]   phase_increment_reg;
    logic [dds_pkg::PHASE_W-1:0]   start_phase_reg;
    logic [dds_pkg::PHASE_W-1:0]   acc_reg;

    logic                          s1_valid_reg;
    logic [dds_pkg::PHASE_W-1:0]   s1_phase_reg;
    logic [dds_pkg::PHASE_W-1:0]   s1_after_reg;
    logic                          s1_last_reg;
    logic signed [dds_pkg::SAMPLE_W-1:0] s1_sine_reg;

    logic                          out_valid_reg;
    logic signed [dds_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic [dds_pkg::PHASE_W-1:0]   out_after_reg;
    logic                          out_last_reg;

    logic                          advance;
    logic                          accept;
    logic [dds_pkg::PHASE_W-1:0]   phase_used;
    logic [dds_pkg::PHASE_W-1:0]   acc_next;
    logic [46:0]                   scaled;
    logic signed [48:0]            num;
    logic                          sh31;
    logic signed [16:0]            ramp;
    logic signed [dds_pkg::SAMPLE_W-1:0] sample_next;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance || !s1_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign phase_used = s_tdata[0] ? start_phase_reg : acc_reg;
    assign acc_next   = phase_used + phase_increment_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg        <= dds_pkg::WAVE_SINE;
            phase_increment_reg <= '0;
            start_phase_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dds_pkg::CFG_WAVEFORM:        waveform_reg <= dds_pkg::wave_t'(cfg_data[1:0]);
                dds_pkg::CFG_PHASE_INCREMENT: phase_increment_reg <= cfg_data;
                dds_pkg::CFG_START_PHASE:     start_phase_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                acc_reg <= acc_next;
            if (s_tready)
                s1_valid_reg <= accept;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            s1_phase_reg <= phase_used;
            s1_after_reg <= acc_next;
            s1_last_reg  <= s_tlast;
            s1_sine_reg  <= sine_rom[phase_used[dds_pkg::PHASE_W-1 -: ROM_BITS]];
        end
        if (advance)
        begin
            out_sample_reg <= sample_next;
            out_after_reg  <= s1_after_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign scaled = 47'(dds_pkg::AMP_U) * 47'(s1_phase_reg);

    always_comb
    begin
        sh31 = 1'b0;
        num  = $signed({2'b00, scaled}) - dds_pkg::AMP_SH30;
        if (waveform_reg == dds_pkg::WAVE_SAWTOOTH)
        begin
            sh31 = 1'b1;
            num  = $signed({2'b00, scaled}) - dds_pkg::AMP_SH31;
        end
        else if (s1_phase_reg[dds_pkg::PHASE_W-1])
        begin
            num = dds_pkg::AMP3_SH30 - $signed({2'b00, scaled});
        end
    end

    assign ramp = dds_pkg::div_trunc(num, sh31);

    always_comb
    begin
        case (waveform_reg)
            dds_pkg::WAVE_SINE:   sample_next = s1_sine_reg;
            dds_pkg::WAVE_SQUARE: sample_next = s1_phase_reg[dds_pkg::PHASE_W-1] ?
                                                dds_pkg::SAMPLE_NEG : dds_pkg::SAMPLE_POS;
            default:              sample_next = ramp[dds_pkg::SAMPLE_W-1:0];
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_after_reg, out_sample_reg};
    assign m_tlast  = out_last_reg;

endmodule
